/* rtl/core/rotary_detent_gesture_accumulator_assert.svh */
// Assertion macros shared by the rotary detent gesture accumulator RTL.
`ifndef ROTARY_DETENT_GESTURE_ACCUMULATOR_ASSERT_SVH
`define ROTARY_DETENT_GESTURE_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RDGA_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rdga assertion failed");
`define RDGA_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("rdga assertion failed");
`else
`define RDGA_ASSERT(label, expr)
`define RDGA_ASSERT_NEXT(label, trig, cons)
`endif
`endif

/* rtl/core/rdga_pkg.sv */
// Package with command codes, widths and helpers for the rotary detent gesture accumulator.
package rdga_pkg;

	localparam int DETENT_W = 7;
	localparam int CLICK_W  = 8;
	localparam int TOTAL_W  = 32;
	localparam int LEFT_W   = 3;

	localparam logic [DETENT_W-1:0] DETENT_SAT = 7'd127;

	typedef enum logic [2:0] {
		CMD_POLL       = 3'd0,
		CMD_PRESS_DOWN = 3'd1,
		CMD_PRESS_UP   = 3'd2,
		CMD_CLICK      = 3'd3,
		CMD_DOUBLE     = 3'd4,
		CMD_LONG       = 3'd5,
		CMD_TAKE       = 3'd6
	} cmd_t;

	// Saturating add of a detent amount to a detent counter.
	function automatic logic [DETENT_W-1:0] sat_add(input logic [DETENT_W-1:0] cnt,
			input logic [DETENT_W-1:0] amt);
		logic [DETENT_W:0] s;
		s = {1'b0, cnt} + {1'b0, amt};
		return s[DETENT_W] ? DETENT_SAT : s[DETENT_W-1:0];
	endfunction

endpackage

/* rtl/core/rotary_detent_gesture_accumulator.sv */
// Top level of the rotary detent gesture accumulator.
// A take beat is held in the input stage, then loaded into the output register.
// Throughput: one input beat per cycle; every command updates state in one pass.
// A take stalls only while the single output register still holds an untaken beat.
// Reset (arst_n, asynchronous, active low) clears all counters, totals and flags.
`include "rotary_detent_gesture_accumulator_assert.svh"
module rotary_detent_gesture_accumulator #(
	parameter int COUNTS_PER_DETENT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic signed [31:0] count_total,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  cw_detents,
	output logic [6:0]  ccw_detents,
	output logic [6:0]  cw_detents_held,
	output logic [6:0]  ccw_detents_held,
	output logic [7:0]  clicks,
	output logic [7:0]  double_clicks,
	output logic [7:0]  long_presses,
	output logic        button_held
);

	localparam int DW = rdga_pkg::DETENT_W;
	localparam int CW = rdga_pkg::CLICK_W;
	localparam int TW = rdga_pkg::TOTAL_W;
	localparam int LW = rdga_pkg::LEFT_W;
	localparam int QK = 12;
	localparam logic [QK:0] RECIP = (QK+1)'(((1 << QK) + COUNTS_PER_DETENT - 1)
		/ COUNTS_PER_DETENT);
	localparam logic [9:0] SAT_MAG = 10'(128 * COUNTS_PER_DETENT);

	// Input stage.
	logic               valid_s1;
	rdga_pkg::cmd_t     cmd_s1;
	logic [TW-1:0]      total_s1;

	// Accumulator state.
	logic [TW-1:0]      last_total_q;
	logic signed [LW-1:0] leftover_q;
	logic [DW-1:0]      cw_q, ccw_q, cw_held_q, ccw_hold_q;
	logic [CW-1:0]      click_q, double_q, long_q;
	logic               held_q, turned_q;

	logic               out_free, s1_fire;

	assign out_free = !out_valid || out_ready;
	assign s1_fire  = valid_s1 && (cmd_s1 != rdga_pkg::CMD_TAKE || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= rdga_pkg::cmd_t'(cmd);
			total_s1 <= count_total;
		end
	end

	// Poll arithmetic.
	logic [TW-1:0] delta;
	logic [TW:0]   sum, mag;
	logic          neg, big, nz;
	logic [1:0]    rem;
	logic [22:0]   prod;
	logic [DW-1:0] amount;
	logic [LW-1:0] leftover_next;

	assign delta = total_s1 - last_total_q;
	assign sum   = {{(TW+1-LW){leftover_q[LW-1]}}, leftover_q} + {delta[TW-1], delta};
	assign neg   = sum[TW];
	assign mag   = neg ? (~sum + 1'b1) : sum;

	generate
		if (COUNTS_PER_DETENT == 3) begin : g_mod3
			logic [TW+1:0] mag_pad;
			logic [5:0]    dsum;
			logic [3:0]    fold;
			assign mag_pad = {1'b0, mag};
			always_comb begin
				dsum = '0;
				for (int i = 0; i < (TW + 2) / 2; i++) begin
					dsum = dsum + 6'(mag_pad[2*i +: 2]);
				end
				fold = 4'(dsum[1:0]) + 4'(dsum[3:2]) + 4'(dsum[5:4]);
				if (fold >= 4'd6) begin
					fold = fold - 4'd6;
				end
				if (fold >= 4'd3) begin
					fold = fold - 4'd3;
				end
				rem = fold[1:0];
			end
		end else begin : g_pow2
			assign rem = mag[1:0] & 2'(COUNTS_PER_DETENT - 1);
		end
	endgenerate

	assign big    = (|mag[TW:10]) || (mag[9:0] >= SAT_MAG);
	assign prod   = {13'd0, mag[9:0] - 10'(rem)} * {10'd0, RECIP};
	assign amount = big ? rdga_pkg::DETENT_SAT : prod[QK +: DW];
	assign nz     = big || (prod[QK +: DW] != '0);
	assign leftover_next = neg ? (~{1'b0, rem} + 1'b1) : {1'b0, rem};

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
			leftover_q   <= '0;
			cw_q         <= '0;
			ccw_q        <= '0;
			cw_held_q    <= '0;
			ccw_hold_q   <= '0;
			click_q      <= '0;
			double_q     <= '0;
			long_q       <= '0;
			held_q       <= 1'b0;
			turned_q     <= 1'b0;
		end else if (s1_fire) begin
			case (cmd_s1)
				rdga_pkg::CMD_POLL: begin
					last_total_q <= total_s1;
					leftover_q   <= leftover_next;
					if (nz) begin
						if (held_q) begin
							turned_q <= 1'b1;
							if (neg) begin
								ccw_hold_q <= rdga_pkg::sat_add(ccw_hold_q, amount);
							end else begin
								cw_held_q <= rdga_pkg::sat_add(cw_held_q, amount);
							end
						end else if (neg) begin
							ccw_q <= rdga_pkg::sat_add(ccw_q, amount);
						end else begin
							cw_q <= rdga_pkg::sat_add(cw_q, amount);
						end
					end
				end
				rdga_pkg::CMD_PRESS_DOWN: begin
					held_q   <= 1'b1;
					turned_q <= 1'b0;
				end
				rdga_pkg::CMD_PRESS_UP: begin
					held_q <= 1'b0;
				end
				rdga_pkg::CMD_CLICK: begin
					if (!turned_q) begin
						click_q <= click_q + 1'b1;
					end
				end
				rdga_pkg::CMD_DOUBLE: begin
					if (!turned_q) begin
						double_q <= double_q + 1'b1;
					end
				end
				rdga_pkg::CMD_LONG: begin
					long_q <= long_q + 1'b1;
				end
				rdga_pkg::CMD_TAKE: begin
					cw_q       <= '0;
					ccw_q      <= '0;
					cw_held_q  <= '0;
					ccw_hold_q <= '0;
					click_q    <= '0;
					double_q   <= '0;
					long_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register.
	logic load_out;
	assign load_out = s1_fire && cmd_s1 == rdga_pkg::CMD_TAKE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cw_detents       <= cw_q;
			ccw_detents      <= ccw_q;
			cw_detents_held  <= cw_held_q;
			ccw_detents_held <= ccw_hold_q;
			clicks           <= click_q;
			double_clicks    <= double_q;
			long_presses     <= long_q;
			button_held      <= held_q;
		end
	end

	logic leftover_ok, press_fire;
	assign leftover_ok = (int'(leftover_q) < COUNTS_PER_DETENT)
		&& (int'(leftover_q) > -COUNTS_PER_DETENT);
	assign press_fire = s1_fire && cmd_s1 == rdga_pkg::CMD_PRESS_DOWN;

	`RDGA_ASSERT(a_leftover_range, leftover_ok)
	`RDGA_ASSERT_NEXT(a_press_clears_turned, press_fire, held_q && !turned_q)
	`RDGA_ASSERT(a_stall_blocks_input, !(valid_s1 && !s1_fire) || !in_ready)

endmodule

/* verif/tb.sv */
// Testbench for the rotary detent gesture accumulator: random handshakes, predicted take reports.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DETENT_COUNTS = 4;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [2:0] op;
		logic [rdga_pkg::TOTAL_W-1:0] total;
	} gesture_event_t;

	typedef struct packed {
		logic [rdga_pkg::DETENT_W-1:0] cw;
		logic [rdga_pkg::DETENT_W-1:0] ccw;
		logic [rdga_pkg::DETENT_W-1:0] cw_held;
		logic [rdga_pkg::DETENT_W-1:0] ccw_hold;
		logic [rdga_pkg::CLICK_W-1:0] clicks;
		logic [rdga_pkg::CLICK_W-1:0] doubles;
		logic [rdga_pkg::CLICK_W-1:0] longs;
		logic held;
	} gesture_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = rdga_pkg::CMD_POLL;
	logic signed [31:0] count_total = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [6:0] cw_detents, ccw_detents, cw_detents_held, ccw_detents_held;
	logic [7:0] clicks, double_clicks, long_presses;
	logic button_held;

	gesture_event_t pending_events[$];
	gesture_report_t expected_reports[$];
	gesture_event_t next_event;
	logic [rdga_pkg::TOTAL_W-1:0] gen_total = '0;
	int burst_left = 0;
	int gap_left = 0;
	int events_accepted = 0;
	int errors = 0;
	int cycles = 0;
	logic hold_off = 1'b0;

	logic [rdga_pkg::TOTAL_W-1:0] last_total = '0;
	int leftover = 0;
	logic [rdga_pkg::DETENT_W-1:0] cw_cnt = '0, ccw_cnt = '0, cw_held_cnt = '0;
	logic [rdga_pkg::DETENT_W-1:0] ccw_hold_cnt = '0;
	logic [rdga_pkg::CLICK_W-1:0] click_cnt = '0, double_cnt = '0, long_cnt = '0;
	logic held = 1'b0;
	logic turned = 1'b0;

	rotary_detent_gesture_accumulator #(
		.COUNTS_PER_DETENT(DETENT_COUNTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.count_total(count_total),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cw_detents(cw_detents),
		.ccw_detents(ccw_detents),
		.cw_detents_held(cw_detents_held),
		.ccw_detents_held(ccw_detents_held),
		.clicks(clicks),
		.double_clicks(double_clicks),
		.long_presses(long_presses),
		.button_held(button_held)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_failure(input string msg);
		$display("error at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic logic [rdga_pkg::DETENT_W-1:0] detent_sat(
			input logic [rdga_pkg::DETENT_W-1:0] cnt, input longint amt);
		if (amt > 127 || longint'(cnt) + amt > 127)
			return 7'd127;
		return rdga_pkg::DETENT_W'(longint'(cnt) + amt);
	endfunction

	task automatic apply_gesture(input logic [2:0] op,
			input logic [rdga_pkg::TOTAL_W-1:0] total);
		logic [rdga_pkg::TOTAL_W-1:0] diff;
		longint sum, detents, mag;
		gesture_report_t rep;
		case (op)
			rdga_pkg::CMD_POLL: begin
				diff = total - last_total;
				sum = longint'(leftover) + longint'($signed(diff));
				detents = sum / DETENT_COUNTS;
				leftover = int'(sum - detents * DETENT_COUNTS);
				last_total = total;
				if (detents != 0) begin
					if (held)
						turned = 1'b1;
					mag = (detents > 0) ? detents : -detents;
					if (detents > 0 && held)
						cw_held_cnt = detent_sat(cw_held_cnt, mag);
					else if (detents > 0)
						cw_cnt = detent_sat(cw_cnt, mag);
					else if (held)
						ccw_hold_cnt = detent_sat(ccw_hold_cnt, mag);
					else
						ccw_cnt = detent_sat(ccw_cnt, mag);
				end
			end
			rdga_pkg::CMD_PRESS_DOWN: begin
				held = 1'b1;
				turned = 1'b0;
			end
			rdga_pkg::CMD_PRESS_UP: held = 1'b0;
			rdga_pkg::CMD_CLICK: if (!turned) click_cnt++;
			rdga_pkg::CMD_DOUBLE: if (!turned) double_cnt++;
			rdga_pkg::CMD_LONG: long_cnt++;
			rdga_pkg::CMD_TAKE: begin
				rep = '{cw_cnt, ccw_cnt, cw_held_cnt, ccw_hold_cnt,
					click_cnt, double_cnt, long_cnt, held};
				expected_reports.push_back(rep);
				cw_cnt = '0;
				ccw_cnt = '0;
				cw_held_cnt = '0;
				ccw_hold_cnt = '0;
				click_cnt = '0;
				double_cnt = '0;
				long_cnt = '0;
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic check_report();
		gesture_report_t want;
		if (expected_reports.size() == 0) begin
			report_failure("output beat with no take pending");
		end else begin
			want = expected_reports.pop_front();
			compare_field("cw_detents", cw_detents, want.cw);
			compare_field("ccw_detents", ccw_detents, want.ccw);
			compare_field("cw_detents_held", cw_detents_held, want.cw_held);
			compare_field("ccw_detents_held", ccw_detents_held, want.ccw_hold);
			compare_field("clicks", clicks, want.clicks);
			compare_field("double_clicks", double_clicks, want.doubles);
			compare_field("long_presses", long_presses, want.longs);
			compare_field("button_held", button_held, want.held);
		end
	endtask

	task automatic add_event(input logic [2:0] op, input logic [rdga_pkg::TOTAL_W-1:0] total);
		if (op == rdga_pkg::CMD_POLL)
			gen_total = total;
		pending_events.push_back('{op, total});
	endtask

	task automatic queue_random_events(input int n, input bit gesture_heavy);
		int pick, mode, delta;
		logic [2:0] op;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (gesture_heavy) begin
				if (pick < 4) op = rdga_pkg::CMD_POLL;
				else if (pick < 7) op = rdga_pkg::CMD_PRESS_DOWN;
				else if (pick < 9) op = rdga_pkg::CMD_PRESS_UP;
				else if (pick < 39) op = rdga_pkg::CMD_CLICK;
				else if (pick < 69) op = rdga_pkg::CMD_DOUBLE;
				else if (pick < 99) op = rdga_pkg::CMD_LONG;
				else op = CMD_UNUSED;
			end else begin
				if (pick < 42) op = rdga_pkg::CMD_POLL;
				else if (pick < 50) op = rdga_pkg::CMD_PRESS_DOWN;
				else if (pick < 58) op = rdga_pkg::CMD_PRESS_UP;
				else if (pick < 70) op = rdga_pkg::CMD_CLICK;
				else if (pick < 80) op = rdga_pkg::CMD_DOUBLE;
				else if (pick < 87) op = rdga_pkg::CMD_LONG;
				else if (pick < 98) op = rdga_pkg::CMD_TAKE;
				else op = CMD_UNUSED;
			end
			if (op == rdga_pkg::CMD_POLL) begin
				mode = $urandom_range(0, 19);
				if (mode == 0) begin
					add_event(op, $urandom);
				end else begin
					if (mode < 4)
						delta = int'($urandom_range(0, 1200)) - 600;
					else
						delta = int'($urandom_range(0, 24)) - 12;
					add_event(op, gen_total + rdga_pkg::TOTAL_W'(delta));
				end
			end else begin
				add_event(op, $urandom);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0 || pending_events.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				next_event = pending_events.pop_front();
				in_valid <= 1'b1;
				cmd <= next_event.op;
				count_total <= next_event.total;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case (cycles[9:8])
				2'd0: out_ready <= !hold_off;
				2'd1: out_ready <= !hold_off && ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= !hold_off && ($urandom_range(0, 3) == 0);
				default: out_ready <= !hold_off && cycles[0];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_gesture(cmd, count_total);
				events_accepted <= events_accepted + 1;
			end
			if (out_valid && out_ready)
				check_report();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		while (events_accepted < 300)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		add_event(rdga_pkg::CMD_POLL, 32'd7);
		add_event(rdga_pkg::CMD_POLL, 32'd2);
		add_event(rdga_pkg::CMD_POLL, 32'h8000_0000);
		add_event(rdga_pkg::CMD_POLL, 32'h7fff_ffff);
		add_event(rdga_pkg::CMD_POLL, 32'h8000_0000);
		add_event(rdga_pkg::CMD_POLL, 32'd0);
		add_event(rdga_pkg::CMD_TAKE, 32'hffff_ffff);
		add_event(rdga_pkg::CMD_PRESS_DOWN, 32'd0);
		add_event(rdga_pkg::CMD_POLL, 32'd8);
		add_event(rdga_pkg::CMD_CLICK, 32'd0);
		add_event(rdga_pkg::CMD_DOUBLE, 32'd0);
		add_event(rdga_pkg::CMD_LONG, 32'd0);
		add_event(rdga_pkg::CMD_PRESS_UP, 32'd0);
		add_event(rdga_pkg::CMD_CLICK, 32'd0);
		add_event(rdga_pkg::CMD_POLL, 32'd4);
		add_event(CMD_UNUSED, 32'h5a5a_a5a5);
		add_event(rdga_pkg::CMD_TAKE, 32'd0);
		add_event(rdga_pkg::CMD_PRESS_DOWN, 32'd0);
		add_event(rdga_pkg::CMD_CLICK, 32'd0);
		add_event(rdga_pkg::CMD_DOUBLE, 32'd0);
		add_event(rdga_pkg::CMD_POLL, 32'hffff_fffc);
		add_event(rdga_pkg::CMD_TAKE, 32'd0);
		add_event(rdga_pkg::CMD_PRESS_UP, 32'd0);
		add_event(rdga_pkg::CMD_TAKE, 32'd0);
		queue_random_events(450, 1'b0);
		queue_random_events(1000, 1'b1);
		add_event(rdga_pkg::CMD_TAKE, $urandom);
		queue_random_events(400, 1'b0);
		add_event(rdga_pkg::CMD_TAKE, $urandom);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() != 0 || in_valid)
			@(posedge clk);
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0)
			report_failure("take reports never arrived");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
